FILE: hdl/pbcp_pkg.sv
// pbcp_pkg: types and constants shared by the packbits channel plane decoder
// no dependencies; imported by every module and interface of the block

package pbcp_pkg;

    localparam int POS_W     = 25;
    localparam int SKIP_W    = 17;
    localparam int IDX_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 25;

    localparam logic [15:0] ID_ALPHA = 16'hFFFF;
    localparam logic [15:0] ID_RED   = 16'h0000;
    localparam logic [15:0] ID_GREEN = 16'h0001;
    localparam logic [15:0] ID_BLUE  = 16'h0002;
    localparam logic [7:0]  HDR_NOP  = 8'd128;
    localparam logic [8:0]  REP_BASE = 9'd257;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_COUNT = 1'b0,
        REG_ROW_COUNT   = 1'b1
    } pbcp_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FLAG_LO = 3'd1,
        PH_TABLE   = 3'd2,
        PH_HEADER  = 3'd3,
        PH_LITERAL = 3'd4,
        PH_REPEAT  = 3'd5,
        PH_RAW     = 3'd6
    } pbcp_phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ID  = 2'd1,
        ST_CLAMPED = 2'd2
    } pbcp_status_t;

    typedef enum logic [1:0] {
        LANE_BLUE  = 2'd0,
        LANE_GREEN = 2'd1,
        LANE_RED   = 2'd2,
        LANE_ALPHA = 2'd3
    } pbcp_lane_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        plane_start;
        logic [15:0] channel_id;
    } pbcp_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index;
        logic [1:0]       byte_lane;
        logic [7:0]       run_length;
        logic [7:0]       fill_value;
        pbcp_status_t     status;
        logic             plane_done;
    } pbcp_result_t;

endpackage

FILE: hdl/pbcp_in_if.sv
// pbcp_in_if: input byte channel, valid/ready plus one stream word
// depends on pbcp_pkg

interface pbcp_in_if
    import pbcp_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        plane_start;
    logic [15:0] channel_id;

    modport source (output valid, output data_byte, output plane_start,
                    output channel_id, input ready);
    modport sink   (input valid, input data_byte, input plane_start,
                    input channel_id, output ready);
endinterface

FILE: hdl/pbcp_out_if.sv
// pbcp_out_if: write command channel, valid/ready plus one command word
// depends on pbcp_pkg

interface pbcp_out_if
    import pbcp_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = 24
) ();
    logic                        valid;
    logic                        ready;
    logic [PIXEL_INDEX_BITS-1:0] pixel_index;
    logic [1:0]                  byte_lane;
    logic [7:0]                  run_length;
    logic [7:0]                  fill_value;
    logic [1:0]                  status;
    logic                        plane_done;

    modport source (output valid, output pixel_index, output byte_lane,
                    output run_length, output fill_value, output status,
                    output plane_done, input ready);
    modport sink   (input valid, input pixel_index, input byte_lane,
                    input run_length, input fill_value, input status,
                    input plane_done, output ready);
endinterface

FILE: hdl/pbcp_cfg_if.sv
// pbcp_cfg_if: configuration write channel, register index and write data
// depends on pbcp_pkg

interface pbcp_cfg_if
    import pbcp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: hdl/pbcp_step.sv
// pbcp_step: plane parser state machine and run command generation
// depends on pbcp_pkg; one registered word is consumed per enabled cycle

module pbcp_step
    import pbcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  pbcp_item_t         item,
    input  logic [POS_W-1:0]   pixel_count,
    input  logic [15:0]        row_count,
    output logic               res_valid,
    output pbcp_result_t       res
);

    pbcp_phase_t       phase_reg, phase_next;
    logic              packed_reg, packed_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        lit_reg, lit_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [1:0]        lane_reg, lane_next;

    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  run_ext;
    logic [7:0]        run;
    logic [7:0]        b;
    logic              done;

    assign b = item.data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            packed_reg <= 1'b0;
            pos_reg    <= '0;
            lit_reg    <= '0;
            skip_reg   <= '0;
            lane_reg   <= '0;
        end
        else if (en)
        begin
            phase_reg  <= phase_next;
            packed_reg <= packed_next;
            pos_reg    <= pos_next;
            lit_reg    <= lit_next;
            skip_reg   <= skip_next;
            lane_reg   <= lane_next;
        end
    end

    // pixels still free in the plane
    assign left = (pos_reg < pixel_count) ? (pixel_count - pos_reg) : '0;

    always_comb
    begin
        phase_next  = phase_reg;
        packed_next = packed_reg;
        pos_next    = pos_reg;
        lit_next    = lit_reg;
        skip_next   = skip_reg;
        lane_next   = lane_reg;
        res_valid   = 1'b0;
        res         = '0;
        run         = 8'd1;
        run_ext     = '0;
        done        = 1'b0;

        if (item.plane_start)
        begin
            if (item.channel_id == ID_ALPHA || item.channel_id == ID_RED ||
                item.channel_id == ID_GREEN || item.channel_id == ID_BLUE)
            begin
                case (item.channel_id)
                    ID_ALPHA: lane_next = LANE_ALPHA;
                    ID_RED:   lane_next = LANE_RED;
                    ID_GREEN: lane_next = LANE_GREEN;
                    default:  lane_next = LANE_BLUE;
                endcase
                packed_next = (b != 8'd0);
                pos_next    = '0;
                lit_next    = '0;
                skip_next   = '0;
                phase_next  = PH_FLAG_LO;
            end
            else
            begin
                phase_next = PH_IDLE;
                res_valid  = en;
                res.status = ST_BAD_ID;
            end
        end
        else
        begin
            case (phase_reg)
                PH_FLAG_LO:
                begin
                    if (packed_reg || b != 8'd0)
                    begin
                        packed_next = 1'b1;
                        skip_next   = {row_count, 1'b0};
                        phase_next  = (row_count != 16'd0) ? PH_TABLE : PH_HEADER;
                    end
                    else
                    begin
                        phase_next = PH_RAW;
                    end
                end
                PH_TABLE:
                begin
                    skip_next = skip_reg - SKIP_W'(1);
                    if (skip_next == '0)
                        phase_next = PH_HEADER;
                end
                PH_HEADER:
                begin
                    if (!b[7])
                    begin
                        lit_next   = {1'b0, b[6:0]} + 8'd1;
                        phase_next = PH_LITERAL;
                    end
                    else if (b != HDR_NOP)
                    begin
                        lit_next   = 8'(REP_BASE - {1'b0, b});
                        phase_next = PH_REPEAT;
                    end
                end
                PH_LITERAL, PH_REPEAT, PH_RAW:
                begin
                    if (left == '0)
                    begin
                        // no room left: plane ends without a command
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res.status = ST_OK;
                        if (phase_reg == PH_REPEAT)
                        begin
                            run = lit_reg;
                            if ({{(POS_W-8){1'b0}}, lit_reg} > left)
                            begin
                                run        = left[7:0];
                                res.status = ST_CLAMPED;
                            end
                            lit_next = '0;
                        end
                        else if (phase_reg == PH_LITERAL)
                        begin
                            lit_next = lit_reg - 8'd1;
                            if (left == POS_W'(1) && lit_next != 8'd0)
                                res.status = ST_CLAMPED;
                        end
                        run_ext = {{(POS_W-8){1'b0}}, run};
                        done    = (run_ext == left);

                        res_valid       = en;
                        res.pixel_index = pos_reg[IDX_W-1:0];
                        res.byte_lane   = lane_reg;
                        res.run_length  = run;
                        res.fill_value  = b;
                        res.plane_done  = done;
                        pos_next        = pos_reg + run_ext;

                        if (done)
                            phase_next = PH_IDLE;
                        else if (phase_reg != PH_RAW && lit_next == 8'd0)
                            phase_next = PH_HEADER;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    a_clamp_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_CLAMPED |-> res.plane_done)
        else $error("clamped run without plane end");

    a_bad_id_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_BAD_ID |-> res.run_length == 8'd0 && !res.plane_done)
        else $error("bad channel command carries a run");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != ST_BAD_ID |-> res.run_length != 8'd0)
        else $error("write command with empty run");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.plane_done || res.status == ST_BAD_ID) |=> phase_reg == PH_IDLE)
        else $error("parser not idle after plane end");

endmodule

FILE: hdl/pbcp_out_reg.sv
// pbcp_out_reg: result register holding one command word for the sink
// depends on pbcp_pkg and pbcp_out_if

module pbcp_out_reg
    import pbcp_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  pbcp_result_t  load_data,
    output logic          space,
    pbcp_out_if.source    cmd
);

    logic         valid_reg, valid_next;
    pbcp_result_t data_reg;

    assign space = !valid_reg || cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (cmd.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    // index bits above the 24-bit position read as zero
    always_comb
    begin
        for (int i = 0; i < PIXEL_INDEX_BITS; i++)
            cmd.pixel_index[i] = (i < IDX_W) ? data_reg.pixel_index[i % IDX_W] : 1'b0;
    end

    assign cmd.valid      = valid_reg;
    assign cmd.byte_lane  = data_reg.byte_lane;
    assign cmd.run_length = data_reg.run_length;
    assign cmd.fill_value = data_reg.fill_value;
    assign cmd.status     = data_reg.status;
    assign cmd.plane_done = data_reg.plane_done;

endmodule

FILE: hdl/packbits_channel_plane_decoder_unit.sv
// packbits_channel_plane_decoder_unit: top level, input register, config registers
// depends on pbcp_pkg, pbcp_in_if, pbcp_out_if, pbcp_cfg_if, pbcp_step, pbcp_out_reg
//
// usage:
//   data_ch takes one stream word per cycle: a data byte, a plane start mark and,
//   with the mark, the channel id of the plane (alpha, red, green or blue).
//   cmd_ch gives zero or one write command per word: first pixel, byte lane,
//   run length, fill value, status and a plane done flag.
//   cfg_ch writes pixel_count (index 0) and row_count (index 1); it is always
//   ready and is meant to be used only while no word is in flight.
// path: an accepted word waits in the input register, passes the parser step and
//   loads its command, if any, into the result register, which presents it on cmd_ch.
// throughput: one word per cycle while cmd_ch is ready or empty, as the parser
//   step between the input register and the result register is combinational.
// reset: parser goes idle waiting for a plane start, both config registers
//   return to 1, no command is pending.
// stall: while a command waits on cmd_ch, a word is still taken only if the input
//   register is empty; once it is full, data_ch drops ready until the command leaves.

module packbits_channel_plane_decoder_unit
    import pbcp_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    pbcp_in_if.sink     data_ch,
    pbcp_out_if.source  cmd_ch,
    pbcp_cfg_if.sink    cfg_ch
);

    logic             in_valid_reg, in_valid_next;
    pbcp_item_t       item_reg;
    logic [POS_W-1:0] pixel_count_reg;
    logic [15:0]      row_count_reg;

    logic             space;
    logic             advance;
    logic             take;
    logic             res_valid;
    pbcp_result_t     res;

    assign advance       = in_valid_reg && space;
    assign data_ch.ready = !in_valid_reg || space;
    assign take          = data_ch.valid && data_ch.ready;
    assign cfg_ch.ready  = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_byte   <= data_ch.data_byte;
            item_reg.plane_start <= data_ch.plane_start;
            item_reg.channel_id  <= data_ch.channel_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= POS_W'(1);
            row_count_reg   <= 16'd1;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_PIXEL_COUNT: pixel_count_reg <= cfg_ch.wdata;
                REG_ROW_COUNT:   row_count_reg   <= cfg_ch.wdata[15:0];
                default:         row_count_reg   <= row_count_reg;
            endcase
        end
    end

    pbcp_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .item        (item_reg),
        .pixel_count (pixel_count_reg),
        .row_count   (row_count_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    pbcp_out_reg #(
        .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res),
        .space     (space),
        .cmd       (cmd_ch)
    );

endmodule

FILE: tb/sv/packbits_channel_plane_decoder_unit_test.sv
// packbits_channel_plane_decoder_unit_test: self-checking bench for the channel plane decoder
// sends stream words and register writes, predicts each write command or takes it from the script and compares it
// depends on pbcp_pkg, pbcp_in_if, pbcp_out_if, pbcp_cfg_if and the decoder top level

module packbits_channel_plane_decoder_unit_test;
    import pbcp_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WORDS_PER_MODE = 410;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_PIXELS,
        ROW_ROWS
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [7:0]       data_byte;
        logic             plane_start;
        logic [15:0]      channel_id;
        logic             typed;
        pbcp_result_t     cmd;
        logic [CFG_W-1:0] reg_val;
    } script_row_t;

    typedef struct {
        bit           typed;
        pbcp_result_t cmd;
    } word_note_t;

    localparam pbcp_result_t NO_CMD     = '0;
    localparam pbcp_result_t BAD_ID_CMD = '{24'd0, 2'd0, 8'd0, 8'd0, ST_BAD_ID, 1'b0};

    localparam script_row_t SCRIPT [32] = '{
        // raw alpha plane of one pixel, then a bad channel id
        '{ROW_WORD, 8'h00, 1'b1, ID_ALPHA, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h00, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'hAB, 1'b0, 16'h0, 1'b1, '{24'd0, LANE_ALPHA, 8'd1, 8'hAB, ST_OK, 1'b1}, '0},
        '{ROW_WORD, 8'h00, 1'b1, 16'h0003, 1'b1, BAD_ID_CMD, '0},
        // packed blue plane, repeat of two clamped to the single pixel
        '{ROW_WORD, 8'h01, 1'b1, ID_BLUE, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h00, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h12, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h34, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'hFF, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h00, 1'b0, 16'h0, 1'b1, '{24'd0, LANE_BLUE, 8'd1, 8'h00, ST_CLAMPED, 1'b1}, '0},
        // packed via the low flag byte, literal run past the end
        '{ROW_WORD, 8'h00, 1'b1, ID_GREEN, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h01, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'hAA, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h55, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h05, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'hFF, 1'b0, 16'h0, 1'b1, '{24'd0, LANE_GREEN, 8'd1, 8'hFF, ST_CLAMPED, 1'b1}, '0},
        '{ROW_PIXELS, 8'h00, 1'b0, 16'h0, 1'b0, NO_CMD, 25'd16777216},
        '{ROW_ROWS, 8'h00, 1'b0, 16'h0, 1'b0, NO_CMD, 25'd0},
        // no line-length table, no-op header, longest repeat
        '{ROW_WORD, 8'h80, 1'b1, ID_RED, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h00, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, HDR_NOP, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h81, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h5A, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        // restart mid-plane, then shrink the plane under the write position
        '{ROW_WORD, 8'h00, 1'b1, ID_RED, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h00, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h77, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_PIXELS, 8'h00, 1'b0, 16'h0, 1'b0, NO_CMD, 25'd1},
        '{ROW_WORD, 8'h66, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        // empty plane
        '{ROW_PIXELS, 8'h00, 1'b0, 16'h0, 1'b0, NO_CMD, 25'd0},
        '{ROW_WORD, 8'h00, 1'b1, ID_BLUE, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h00, 1'b0, 16'h0, 1'b0, NO_CMD, '0},
        '{ROW_WORD, 8'h10, 1'b0, 16'h0, 1'b0, NO_CMD, '0}
    };

    logic clk;
    logic rst_n;

    pbcp_in_if                          data_ch();
    pbcp_out_if #(.PIXEL_INDEX_BITS(IDX_W)) cmd_ch();
    pbcp_cfg_if                         cfg_ch();

    packbits_channel_plane_decoder_unit #(
        .PIXEL_INDEX_BITS(IDX_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .data_ch(data_ch),
        .cmd_ch (cmd_ch),
        .cfg_ch (cfg_ch)
    );

    // decoder mirror
    logic [CFG_W-1:0]  cfg_pixels;
    logic [15:0]       cfg_rows;
    pbcp_phase_t       plane_phase;
    logic              packed_flag;
    logic [POS_W-1:0]  next_pixel;
    logic [7:0]        run_left;
    logic [SKIP_W-1:0] table_left;
    pbcp_lane_t        plane_lane;

    pbcp_result_t expected_cmds [$];
    word_note_t   word_notes [$];

    word_note_t   taken_note;
    pbcp_item_t   taken_word;
    pbcp_result_t predicted_cmd;
    pbcp_result_t want_cmd;
    bit           has_cmd;

    int mismatches    = 0;
    int cycles        = 0;
    int words_sent    = 0;
    int send_idle_pct = 27;
    int recv_idle_pct = 60;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit decode_byte(input pbcp_item_t w, output pbcp_result_t r);
        logic [POS_W-1:0] pixels_left;
        logic [7:0]       run;
        pbcp_status_t     st;
        r = '0;
        if (w.plane_start)
        begin
            case (w.channel_id)
                ID_ALPHA: plane_lane = LANE_ALPHA;
                ID_RED:   plane_lane = LANE_RED;
                ID_GREEN: plane_lane = LANE_GREEN;
                ID_BLUE:  plane_lane = LANE_BLUE;
                default:
                begin
                    plane_phase = PH_IDLE;
                    r.status = ST_BAD_ID;
                    return 1'b1;
                end
            endcase
            packed_flag = (w.data_byte != 8'd0);
            next_pixel  = '0;
            run_left    = '0;
            table_left  = '0;
            plane_phase = PH_FLAG_LO;
            return 1'b0;
        end
        case (plane_phase)
            PH_FLAG_LO:
            begin
                if (w.data_byte != 8'd0)
                    packed_flag = 1'b1;
                if (packed_flag)
                begin
                    table_left  = {cfg_rows, 1'b0};
                    plane_phase = (table_left != '0) ? PH_TABLE : PH_HEADER;
                end
                else
                    plane_phase = PH_RAW;
                return 1'b0;
            end
            PH_TABLE:
            begin
                table_left--;
                if (table_left == '0)
                    plane_phase = PH_HEADER;
                return 1'b0;
            end
            PH_HEADER:
            begin
                if (w.data_byte < HDR_NOP)
                begin
                    run_left    = w.data_byte + 8'd1;
                    plane_phase = PH_LITERAL;
                end
                else if (w.data_byte > HDR_NOP)
                begin
                    run_left    = 8'(REP_BASE - {1'b0, w.data_byte});
                    plane_phase = PH_REPEAT;
                end
                return 1'b0;
            end
            PH_LITERAL, PH_REPEAT, PH_RAW: ;
            default: return 1'b0;
        endcase

        pixels_left = (next_pixel < cfg_pixels) ? cfg_pixels - next_pixel : '0;
        if (pixels_left == '0)
        begin
            plane_phase = PH_IDLE;
            return 1'b0;
        end
        st = ST_OK;
        if (plane_phase == PH_REPEAT)
        begin
            run = run_left;
            if (POS_W'(run_left) > pixels_left)
            begin
                run = pixels_left[7:0];
                st  = ST_CLAMPED;
            end
            run_left = '0;
        end
        else
        begin
            run = 8'd1;
            if (plane_phase == PH_LITERAL)
            begin
                run_left--;
                // last pixel taken while literals remain
                if (pixels_left == POS_W'(1) && run_left != '0)
                    st = ST_CLAMPED;
            end
        end
        r.pixel_index = next_pixel[IDX_W-1:0];
        r.byte_lane   = plane_lane;
        r.run_length  = run;
        r.fill_value  = w.data_byte;
        r.status      = st;
        r.plane_done  = (POS_W'(run) == pixels_left);
        next_pixel    = next_pixel + POS_W'(run);
        if (POS_W'(run) == pixels_left)
            plane_phase = PH_IDLE;
        else if (plane_phase != PH_RAW && run_left == '0)
            plane_phase = PH_HEADER;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_pixels  = CFG_W'(1);
            cfg_rows    = 16'd1;
            plane_phase = PH_IDLE;
            packed_flag = 1'b0;
            next_pixel  = '0;
            run_left    = '0;
            table_left  = '0;
            plane_lane  = LANE_BLUE;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $error("command with nothing expected: pixel_index %0d fill_value %0d",
                           cmd_ch.pixel_index, cmd_ch.fill_value);
                    mismatches++;
                end
                else
                begin
                    want_cmd = expected_cmds.pop_front();
                    check_field("pixel_index", want_cmd.pixel_index, cmd_ch.pixel_index);
                    check_field("byte_lane", want_cmd.byte_lane, cmd_ch.byte_lane);
                    check_field("run_length", want_cmd.run_length, cmd_ch.run_length);
                    check_field("fill_value", want_cmd.fill_value, cmd_ch.fill_value);
                    check_field("status", want_cmd.status, cmd_ch.status);
                    check_field("plane_done", want_cmd.plane_done, cmd_ch.plane_done);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (pbcp_reg_t'(cfg_ch.index))
                    REG_PIXEL_COUNT: cfg_pixels = cfg_ch.wdata;
                    REG_ROW_COUNT:   cfg_rows   = cfg_ch.wdata[15:0];
                    default: ;
                endcase
            end
            if (data_ch.valid && data_ch.ready)
            begin
                taken_note             = word_notes.pop_front();
                taken_word.data_byte   = data_ch.data_byte;
                taken_word.plane_start = data_ch.plane_start;
                taken_word.channel_id  = data_ch.channel_id;
                has_cmd = decode_byte(taken_word, predicted_cmd);
                if (taken_note.typed)
                    expected_cmds.push_back(taken_note.cmd);
                else if (has_cmd)
                    expected_cmds.push_back(predicted_cmd);
            end
        end
    end

    always @(posedge clk)
        cmd_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("packbits_channel_plane_decoder_unit_test failed");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // valid stays high into the next word unless a gap is drawn
    task automatic send_word(input logic [7:0] b, input logic s, input logic [15:0] id,
                             input bit typed, input pbcp_result_t cmd);
        word_note_t note;
        note.typed = typed;
        note.cmd   = cmd;
        while ($urandom_range(99) < send_idle_pct)
        begin
            data_ch.valid <= 1'b0;
            @(posedge clk);
        end
        word_notes.push_back(note);
        data_ch.valid       <= 1'b1;
        data_ch.data_byte   <= b;
        data_ch.plane_start <= s;
        data_ch.channel_id  <= id;
        @(posedge clk);
        while (!data_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(b, 1'b0, 16'($urandom), 1'b0, NO_CMD);
    endtask

    task automatic drain(input int extra);
        data_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input pbcp_reg_t idx, input logic [CFG_W-1:0] val);
        drain(SETTLE_CYCLES);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // clean planes always carry a good id, are packed and run to the end
    task automatic send_plane(input int pixels, input int rows, input bit clean);
        int          pick;
        int          covered;
        int          count;
        int          stop_at;
        logic [15:0] id;
        logic [7:0]  flag_hi;
        logic [7:0]  flag_lo;
        bit          raw;
        pick = $urandom_range(99);
        case (pick % 4)
            0:       id = ID_ALPHA;
            1:       id = ID_RED;
            2:       id = ID_GREEN;
            default: id = ID_BLUE;
        endcase
        if (!clean && pick < 6)
        begin
            id = 16'd3 + 16'($urandom_range(16'hFFFB));
            send_word(rand_byte(), 1'b1, id, 1'b0, NO_CMD);
            repeat ($urandom_range(3)) send_byte(rand_byte());
            return;
        end
        raw = !clean && ($urandom_range(2) == 0);
        flag_hi = 8'd0;
        flag_lo = 8'd0;
        if (!raw)
        begin
            if ($urandom_range(1) == 1)
            begin
                flag_hi = 8'($urandom_range(1, 255));
                flag_lo = rand_byte();
            end
            else
                flag_lo = 8'($urandom_range(1, 255));
        end
        send_word(flag_hi, 1'b1, id, 1'b0, NO_CMD);
        send_byte(flag_lo);
        if (!raw)
            repeat (2 * rows) send_byte(rand_byte());
        // now and then a plane is cut short and abandoned by the next start
        stop_at = (!clean && $urandom_range(9) == 0) ? $urandom_range(pixels) : pixels;
        covered = 0;
        while (covered < stop_at)
        begin
            if (raw)
            begin
                send_byte(rand_byte());
                covered++;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    send_byte(HDR_NOP);
                else if (pick < 55)
                begin
                    count = ($urandom_range(9) == 0) ? $urandom_range(1, 128)
                                                     : $urandom_range(1, 4);
                    send_byte(8'(count - 1));
                    repeat (count) send_byte(rand_byte());
                    covered += count;
                end
                else
                begin
                    count = ($urandom_range(9) == 0) ? $urandom_range(2, 128)
                                                     : $urandom_range(2, 6);
                    send_byte(8'(REP_BASE - 9'(count)));
                    send_byte(rand_byte());
                    covered += count;
                end
            end
        end
        if (!clean && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(rand_byte());
    endtask

    initial
    begin
        int goal;
        int batch;
        int pick;
        int pixels;
        int rows;

        rst_n               = 1'b0;
        data_ch.valid       = 1'b0;
        data_ch.data_byte   = '0;
        data_ch.plane_start = 1'b0;
        data_ch.channel_id  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_PIXEL_COUNT;
        cfg_ch.wdata        = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (SCRIPT[i])
        begin
            case (SCRIPT[i].kind)
                ROW_PIXELS: write_reg(REG_PIXEL_COUNT, SCRIPT[i].reg_val);
                ROW_ROWS:   write_reg(REG_ROW_COUNT, SCRIPT[i].reg_val);
                default:    send_word(SCRIPT[i].data_byte, SCRIPT[i].plane_start,
                                      SCRIPT[i].channel_id, SCRIPT[i].typed, SCRIPT[i].cmd);
            endcase
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 60 : 0;
            recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 27 : 0;
            goal = words_sent + WORDS_PER_MODE;
            while (words_sent < goal)
            begin
                pick   = $urandom_range(9);
                pixels = (pick == 0) ? 1 : (pick == 1) ? $urandom_range(150, 400)
                                                       : $urandom_range(2, 40);
                rows   = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 3);
                write_reg(REG_PIXEL_COUNT, CFG_W'(pixels));
                write_reg(REG_ROW_COUNT, CFG_W'(rows));
                batch = words_sent + 100;
                while (words_sent < batch && words_sent < goal)
                begin
                    if ($urandom_range(11) == 0)
                        repeat ($urandom_range(1, 4)) send_byte(rand_byte());
                    send_plane(pixels, rows, 1'b0);
                end
            end
        end

        // longest line-length table cut short by a restart, then runs of a huge plane
        write_reg(REG_PIXEL_COUNT, CFG_W'(24'hFFFFFF));
        write_reg(REG_ROW_COUNT, CFG_W'(16'hFFFF));
        send_word(8'h01, 1'b1, ID_ALPHA, 1'b0, NO_CMD);
        send_byte(rand_byte());
        repeat (20) send_byte(rand_byte());
        write_reg(REG_ROW_COUNT, CFG_W'(1));
        send_plane(40, 1, 1'b1);

        drain(10);
        if (mismatches == 0)
            $display("packbits_channel_plane_decoder_unit_test passed");
        else
            $display("packbits_channel_plane_decoder_unit_test failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/pbcp_pkg.sv
hdl/pbcp_in_if.sv
hdl/pbcp_out_if.sv
hdl/pbcp_cfg_if.sv
hdl/pbcp_step.sv
hdl/pbcp_out_reg.sv
hdl/packbits_channel_plane_decoder_unit.sv
tb/sv/packbits_channel_plane_decoder_unit_test.sv
